### design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the line and packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // reset values of the sync registers
  localparam logic [7:0] SYNC_FIRST_RESET  = 8'hA5;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'h5A;

  // byte that ends a line
  localparam logic [7:0] NEWLINE = 8'h0A;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // output tdata width: data, packet_id, command, body_length, padded to bytes
  localparam int TDATA_WIDTH = 40;

  // register indexes on the configuration port
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  // result kinds
  typedef enum logic [2:0] {
    KIND_LINE_BYTE = 3'd0,
    KIND_LINE_END  = 3'd1,
    KIND_HEADER    = 3'd2,
    KIND_BODY_BYTE = 3'd3,
    KIND_END_GOOD  = 3'd4,
    KIND_END_BAD   = 3'd5
  } kind_t;

  // work for the back part: an optional held sync byte, then an optional item
  typedef struct packed {
    logic        held_valid;
    logic [7:0]  held_data;
    logic        main_valid;
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  packet_id;
    logic [6:0]  command;
    logic [15:0] body_length;
  } lpd_entry_t;

endpackage

### design/line_and_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// line_and_packet_deframer_top
// Splits a received byte stream into line items and sync-framed packets with
// header, body and checksum end items; sync bytes set over an APB port.
// ----------------------------------------------------------------------------
// path: an accepted byte's entry is written into the queue, and its first
//   result is then loaded from the queue into the output register
// throughput: one byte per cycle while the queue has room; a byte that
//   releases a held sync byte can give two results, absorbed by the queue
// reset: synchronous; clears framing state, queue and output valid, and sets
//   the sync registers to 0xA5 and 0x5A
module line_and_packet_deframer_top
  import lpd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // [7:0] rx_byte
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_WIDTH-1:0] m_tdata,   // [7:0] data, [15:8] packet_id,
                                            // [22:16] command,
                                            // [38:23] body_length, [39] zero
  output logic [2:0]             m_tuser,   // [2:0] kind
  output logic                   m_tlast,   // run_last
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [7:0] sync_first, sync_second;
  logic       in_fire;
  logic       push, pop;
  logic       not_empty, not_full;
  logic       cfg_write;
  logic       reg_sel;
  lpd_entry_t push_entry, head;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  // sync registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_SYNC_FIRST:  sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second <= pwdata[7:0];
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (reg_sel)
      REG_SYNC_FIRST:  prdata = {24'h000000, sync_first};
      REG_SYNC_SECOND: prdata = {24'h000000, sync_second};
    endcase
  end

  // accept a byte whenever the queue has room
  assign s_tready = not_full;
  assign in_fire  = s_tvalid && s_tready;

  lpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .in_fire     (in_fire),
    .rx_byte     (s_tdata),
    .push        (push),
    .push_entry  (push_entry)
  );

  lpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .not_full   (not_full)
  );

  lpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

### design/lpd_front.sv
// ----------------------------------------------------------------------------
// lpd_front
// Takes received bytes, tracks line and packet framing, and turns each byte
// that causes a result into one queue entry holding the results that it causes.
// ----------------------------------------------------------------------------
module lpd_front
  import lpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  output logic       push,
  output lpd_entry_t push_entry
);

  typedef enum logic [6:0] {
    ST_LINE  = 7'b0000001,
    ST_ID    = 7'b0000010,
    ST_CMD   = 7'b0000100,
    ST_LEN1  = 7'b0001000,
    ST_LEN2  = 7'b0010000,
    ST_BODY  = 7'b0100000,
    ST_CHECK = 7'b1000000
  } state_t;

  state_t      state, state_next;
  logic        sync_pending, sync_pending_next;
  logic [7:0]  cur_id, cur_id_next;
  logic [7:0]  cur_cmd, cur_cmd_next;
  logic [15:0] decl_len, decl_len_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  run_xor, run_xor_next;
  logic [15:0] seen_inc;
  lpd_entry_t  entry;

  assign seen_inc = bytes_seen + 16'd1;

  // per-byte framing update
  always_comb begin
    state_next        = state;
    sync_pending_next = sync_pending;
    cur_id_next       = cur_id;
    cur_cmd_next      = cur_cmd;
    decl_len_next     = decl_len;
    bytes_seen_next   = bytes_seen;
    run_xor_next      = run_xor;
    entry             = '0;

    unique case (state)
      ST_ID: begin
        cur_id_next  = rx_byte;
        run_xor_next = run_xor ^ rx_byte;
        state_next   = ST_CMD;
      end
      ST_CMD: begin
        cur_cmd_next = rx_byte;
        run_xor_next = run_xor ^ rx_byte;
        state_next   = ST_LEN1;
      end
      ST_LEN1: begin
        run_xor_next = run_xor ^ rx_byte;
        if (cur_cmd[7]) begin
          decl_len_next = {rx_byte, 8'h00};
          state_next    = ST_LEN2;
        end else begin
          decl_len_next   = {8'h00, rx_byte};
          bytes_seen_next = '0;
          entry.main_valid = 1'b1;
          entry.kind       = KIND_HEADER;
          state_next = (rx_byte != 8'h00) ? ST_BODY : ST_CHECK;
        end
      end
      ST_LEN2: begin
        run_xor_next    = run_xor ^ rx_byte;
        decl_len_next   = {decl_len[15:8], rx_byte};
        bytes_seen_next = '0;
        entry.main_valid = 1'b1;
        entry.kind       = KIND_HEADER;
        state_next = ({decl_len[15:8], rx_byte} != 16'h0000) ? ST_BODY : ST_CHECK;
      end
      ST_BODY: begin
        run_xor_next    = run_xor ^ rx_byte;
        bytes_seen_next = seen_inc;
        entry.main_valid = 1'b1;
        entry.kind       = KIND_BODY_BYTE;
        entry.data       = rx_byte;
        if (seen_inc == decl_len) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        entry.main_valid = 1'b1;
        entry.kind       = (rx_byte == run_xor) ? KIND_END_GOOD : KIND_END_BAD;
        sync_pending_next = 1'b0;
        state_next        = ST_LINE;
      end
      default: begin
        // line mode; a held sync byte is resolved first
        state_next = ST_LINE;
        if (sync_pending && rx_byte == sync_second) begin
          sync_pending_next = 1'b0;
          run_xor_next      = sync_first ^ sync_second;
          state_next        = ST_ID;
        end else begin
          sync_pending_next = 1'b0;
          entry.held_valid  = sync_pending;
          entry.held_data   = sync_first;
          if (rx_byte == NEWLINE) begin
            entry.main_valid = 1'b1;
            entry.kind       = KIND_LINE_END;
            entry.data       = NEWLINE;
          end else if (rx_byte == sync_first) begin
            sync_pending_next = 1'b1;
          end else begin
            entry.main_valid = 1'b1;
            entry.kind       = KIND_LINE_BYTE;
            entry.data       = rx_byte;
          end
        end
      end
    endcase

    // packet items carry the current packet fields
    if (state != ST_LINE) begin
      entry.packet_id   = cur_id_next;
      entry.command     = cur_cmd_next[6:0];
      entry.body_length = decl_len_next;
    end
  end

  // queue push when the byte causes any result
  assign push       = in_fire && (entry.held_valid || entry.main_valid);
  assign push_entry = entry;

  // framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LINE;
      sync_pending <= 1'b0;
      cur_id       <= '0;
      cur_cmd      <= '0;
      decl_len     <= '0;
      bytes_seen   <= '0;
      run_xor      <= '0;
    end else if (in_fire) begin
      state        <= state_next;
      sync_pending <= sync_pending_next;
      cur_id       <= cur_id_next;
      cur_cmd      <= cur_cmd_next;
      decl_len     <= decl_len_next;
      bytes_seen   <= bytes_seen_next;
      run_xor      <= run_xor_next;
    end
  end

endmodule

### design/lpd_queue.sv
// ----------------------------------------------------------------------------
// lpd_queue
// Short register queue of work entries between the front and the back part.
// ----------------------------------------------------------------------------
module lpd_queue
  import lpd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lpd_entry_t push_entry,
  input  logic       pop,
  output lpd_entry_t head,
  output logic       not_empty,
  output logic       not_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lpd_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign not_full  = (count != FULL_CNT);

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### design/lpd_back.sv
// ----------------------------------------------------------------------------
// lpd_back
// Unpacks queue entries into one or two result items and drives the
// registered output stream.
// ----------------------------------------------------------------------------
module lpd_back
  import lpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  lpd_entry_t             head,
  input  logic                   not_empty,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_WIDTH-1:0] m_tdata,
  output logic [2:0]             m_tuser,
  output logic                   m_tlast
);

  logic                   held_done;
  logic                   load;
  logic                   take_held;
  logic [TDATA_WIDTH-1:0] tdata_next;
  logic [2:0]             tuser_next;
  logic                   tlast_next;

  assign load      = not_empty && (!m_tvalid || m_tready);
  assign take_held = head.held_valid && !held_done;
  assign pop       = load && (!take_held || !head.main_valid);

  // choose the next item of the head entry
  always_comb begin
    if (take_held) begin
      tdata_next = {1'b0, 16'h0000, 7'h00, 8'h00, head.held_data};
      tuser_next = KIND_LINE_BYTE;
      tlast_next = !head.main_valid;
    end else begin
      tdata_next = {1'b0, head.body_length, head.command, head.packet_id, head.data};
      tuser_next = head.kind;
      tlast_next = 1'b1;
    end
  end

  // held byte sent, main item still to go
  always_ff @(posedge clk) begin
    if (rst) begin
      held_done <= 1'b0;
    end else if (load) begin
      held_done <= take_held && head.main_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= tdata_next;
      m_tuser <= tuser_next;
      m_tlast <= tlast_next;
    end
  end

endmodule
